// ===== rtl/ttyb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttyb_pkg
// Shared types and constants of the terminal line buffer: character codes,
// result kinds, register indexes, the command word between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package ttyb_pkg;

   localparam int DEF_STORE_DEPTH = 1024;
   localparam int DEF_MAX_READ    = 64;

   localparam int LIMIT_W = 7;

   localparam logic [7:0] CH_NL = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_SP = 8'h20;

   localparam logic [1:0] KIND_ECHO  = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   localparam logic [1:0] REG_CRLF  = 2'd0;
   localparam logic [1:0] REG_ECHO  = 2'd1;
   localparam logic [1:0] REG_CANON = 2'd2;

   typedef enum logic [1:0] {
      OP_APPEND,
      OP_ERASE,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [7:0]          data;
      logic [LIMIT_W-1:0]  limit;
   } cmd_type;

   typedef struct packed {
      logic crlf;
      logic echo;
      logic canon;
   } cfg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WAIT,
      S_ECHO,
      S_MARK,
      S_SCAN,
      S_EMIT
   } back_state_type;

endpackage

`default_nettype wire

// ===== rtl/ttyb_front.sv =====
// ----------------------------------------------------------------------------
// ttyb_front
// Accepts request items, maps carriage return, classifies each item as
// append, erase or read, saturates the read limit and queues the command.
// ----------------------------------------------------------------------------
`default_nettype none

module ttyb_front #(
   parameter int MAX_READ = ttyb_pkg::DEF_MAX_READ
) (
   input  wire                              clock,
   input  wire                              reset,
   input  ttyb_pkg::cfg_type                cfg,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_cmd,
   input  wire  [7:0]                       req_in_byte,
   input  wire  [ttyb_pkg::LIMIT_W-1:0]     req_read_limit,
   output logic                             q_valid,
   output ttyb_pkg::cmd_type                q_item,
   input  wire                              q_pop
);

   localparam int LW = ttyb_pkg::LIMIT_W;

   ttyb_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   ttyb_pkg::cmd_type cls;
   logic [7:0]        ch;
   logic              push;

   // classify the incoming item
   always_comb begin
      ch = (cfg.crlf && req_in_byte == ttyb_pkg::CH_CR) ? ttyb_pkg::CH_NL : req_in_byte;
      cls.data  = ch;
      cls.limit = (req_read_limit > LW'(MAX_READ)) ? LW'(MAX_READ) : req_read_limit;
      if (req_cmd) begin
         cls.op = ttyb_pkg::OP_READ;
      end else if (cfg.canon && ch == ttyb_pkg::CH_BS) begin
         cls.op = ttyb_pkg::OP_ERASE;
      end else begin
         cls.op = ttyb_pkg::OP_APPEND;
      end
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ttyb_back.sv =====
// ----------------------------------------------------------------------------
// ttyb_back
// Executes queued commands against the ring store: appends, erases, echoes,
// and two-pass reads (scan for length and newlines, then emit), with the
// result register toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ttyb_back #(
   parameter int STORE_DEPTH = ttyb_pkg::DEF_STORE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  ttyb_pkg::cfg_type    cfg,
   input  wire                  q_valid,
   input  ttyb_pkg::cmd_type    q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last,
   output logic                 rsp_readable,
   output logic                 rsp_overflow
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = AW + 1;
   localparam int LW = ttyb_pkg::LIMIT_W;
   localparam int XW = (CW > LW) ? CW : LW;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(off);
      if (s >= (CW+1)'(STORE_DEPTH)) begin
         s = s - (CW+1)'(STORE_DEPTH);
      end
      return s[AW-1:0];
   endfunction

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rdata_ff;

   ttyb_pkg::back_state_type state_ff, state_in;
   logic [AW-1:0] rp_ff, rp_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] nl_ff, nl_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          dv_ff, dv_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic [LW-1:0] tot_ff, tot_in;
   logic [LW-1:0] nlc_ff, nlc_in;
   logic [LW-1:0] lim_ff, lim_in;
   logic [7:0]    byte_ff, byte_in;
   logic [1:0]    ecnt_ff, ecnt_in;
   logic [1:0]    eidx_ff, eidx_in;
   logic          ovf_ff, ovf_in;
   logic          rd_ff, rd_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    kind_ff;
   logic [7:0]    obyte_ff;
   logic          last_ff, rdbl_ff, oflow_ff;

   logic          we, re, load, can_load, have, scan_done, is_last;
   logic [AW-1:0] waddr, raddr;
   logic [1:0]    ecnt, ld_kind;
   logic [7:0]    ld_byte;
   logic          ld_last, ld_ovf;

   always_comb begin
      state_in = state_ff;
      rp_in    = rp_ff;
      fill_in  = fill_ff;
      nl_in    = nl_ff;
      ptr_in   = ptr_ff;
      dv_in    = dv_ff;
      cnt_in   = cnt_ff;
      tot_in   = tot_ff;
      nlc_in   = nlc_ff;
      lim_in   = lim_ff;
      byte_in  = byte_ff;
      ecnt_in  = ecnt_ff;
      eidx_in  = eidx_ff;
      ovf_in   = ovf_ff;
      rd_in    = rd_ff;
      q_pop    = 1'b0;
      we       = 1'b0;
      waddr    = wrap_add(rp_ff, fill_ff);
      re       = 1'b0;
      raddr    = ptr_ff;
      load     = 1'b0;
      ld_kind  = ttyb_pkg::KIND_ECHO;
      ld_byte  = byte_ff;
      ld_last  = 1'b0;
      ld_ovf   = 1'b0;
      scan_done = 1'b0;
      is_last   = 1'b0;
      can_load = !rsp_valid_ff || !rsp_stall;
      have     = cfg.canon ? (nl_ff != '0) : (fill_ff != '0);
      if (!cfg.echo) begin
         ecnt = 2'd0;
      end else if (q_item.data == ttyb_pkg::CH_BS) begin
         ecnt = (fill_ff != '0) ? 2'd3 : 2'd0;
      end else begin
         ecnt = 2'd1;
      end

      case (state_ff)
         ttyb_pkg::S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               byte_in = q_item.data;
               ecnt_in = ecnt;
               eidx_in = 2'd0;
               ovf_in  = 1'b0;
               case (q_item.op)
                  ttyb_pkg::OP_APPEND: begin
                     if (fill_ff == CW'(STORE_DEPTH)) begin
                        ovf_in = 1'b1;
                        rd_in  = have;
                     end else begin
                        we      = 1'b1;
                        fill_in = fill_ff + 1'b1;
                        nl_in   = nl_ff + CW'(q_item.data == ttyb_pkg::CH_NL);
                        rd_in   = cfg.canon ? (nl_in != '0) : (fill_in != '0);
                     end
                     state_in = (ecnt != 2'd0) ? ttyb_pkg::S_ECHO : ttyb_pkg::S_IDLE;
                  end
                  ttyb_pkg::OP_ERASE: begin
                     // fetch the last stored byte to see whether it is a newline
                     if (fill_ff != '0) begin
                        re       = 1'b1;
                        raddr    = wrap_add(rp_ff, fill_ff - 1'b1);
                        state_in = ttyb_pkg::S_WAIT;
                     end
                  end
                  ttyb_pkg::OP_READ: begin
                     lim_in = q_item.limit;
                     if (q_item.limit == '0 || !have) begin
                        rd_in    = have;
                        state_in = ttyb_pkg::S_MARK;
                     end else begin
                        ptr_in   = rp_ff;
                        dv_in    = 1'b0;
                        cnt_in   = '0;
                        nlc_in   = '0;
                        state_in = ttyb_pkg::S_SCAN;
                     end
                  end
                  default: begin
                     state_in = ttyb_pkg::S_IDLE;
                  end
               endcase
            end
         end
         ttyb_pkg::S_WAIT: begin
            fill_in  = fill_ff - 1'b1;
            nl_in    = nl_ff - CW'(rdata_ff == ttyb_pkg::CH_NL);
            rd_in    = cfg.canon ? (nl_in != '0) : (fill_in != '0);
            state_in = (ecnt_ff != 2'd0) ? ttyb_pkg::S_ECHO : ttyb_pkg::S_IDLE;
         end
         ttyb_pkg::S_ECHO: begin
            if (can_load) begin
               load    = 1'b1;
               ld_kind = ttyb_pkg::KIND_ECHO;
               if (ecnt_ff == 2'd3) begin
                  ld_byte = (eidx_ff == 2'd1) ? ttyb_pkg::CH_SP : ttyb_pkg::CH_BS;
               end else begin
                  ld_byte = byte_ff;
               end
               ld_last = (eidx_ff == ecnt_ff - 2'd1);
               ld_ovf  = ovf_ff;
               eidx_in = eidx_ff + 2'd1;
               if (ld_last) begin
                  state_in = ttyb_pkg::S_IDLE;
               end
            end
         end
         ttyb_pkg::S_MARK: begin
            if (can_load) begin
               load     = 1'b1;
               ld_kind  = ttyb_pkg::KIND_EMPTY;
               ld_byte  = 8'h00;
               ld_last  = 1'b1;
               state_in = ttyb_pkg::S_IDLE;
            end
         end
         ttyb_pkg::S_SCAN: begin
            // stream addresses; examine the byte fetched the cycle before
            re     = 1'b1;
            ptr_in = wrap_add(ptr_ff, CW'(1));
            dv_in  = 1'b1;
            if (dv_ff) begin
               cnt_in = cnt_ff + 1'b1;
               nlc_in = nlc_ff + LW'(rdata_ff == ttyb_pkg::CH_NL);
               scan_done = (cfg.canon && rdata_ff == ttyb_pkg::CH_NL) ||
                           (cnt_in == lim_ff) || (XW'(cnt_in) == XW'(fill_ff));
               if (scan_done) begin
                  tot_in   = cnt_in;
                  fill_in  = fill_ff - CW'(cnt_in);
                  nl_in    = nl_ff - CW'(nlc_in);
                  rd_in    = cfg.canon ? (nl_in != '0) : (fill_in != '0);
                  ptr_in   = rp_ff;
                  rp_in    = wrap_add(rp_ff, CW'(cnt_in));
                  dv_in    = 1'b0;
                  cnt_in   = '0;
                  state_in = ttyb_pkg::S_EMIT;
               end
            end
         end
         ttyb_pkg::S_EMIT: begin
            re = !dv_ff || can_load;
            if (re) begin
               ptr_in = wrap_add(ptr_ff, CW'(1));
               dv_in  = 1'b1;
            end
            if (dv_ff && can_load) begin
               is_last = (cnt_ff + 1'b1 == tot_ff);
               load    = 1'b1;
               ld_kind = ttyb_pkg::KIND_DATA;
               ld_byte = rdata_ff;
               ld_last = is_last;
               cnt_in  = cnt_ff + 1'b1;
               if (is_last) begin
                  dv_in    = 1'b0;
                  state_in = ttyb_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = ttyb_pkg::S_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= byte_in;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttyb_pkg::S_IDLE;
         rp_ff        <= '0;
         fill_ff      <= '0;
         nl_ff        <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
         nl_ff        <= nl_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      cnt_ff  <= cnt_in;
      tot_ff  <= tot_in;
      nlc_ff  <= nlc_in;
      lim_ff  <= lim_in;
      byte_ff <= byte_in;
      ecnt_ff <= ecnt_in;
      eidx_ff <= eidx_in;
      ovf_ff  <= ovf_in;
      rd_ff   <= rd_in;
      if (load) begin
         kind_ff  <= ld_kind;
         obyte_ff <= ld_byte;
         last_ff  <= ld_last;
         rdbl_ff  <= rd_ff;
         oflow_ff <= ld_ovf;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_out_byte = obyte_ff;
   assign rsp_last     = last_ff;
   assign rsp_readable = rdbl_ff;
   assign rsp_overflow = oflow_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(STORE_DEPTH))
      else $error("fill count above store depth");

   a_nl_bound: assert property (@(posedge clock) disable iff (reset)
      nl_ff <= fill_ff)
      else $error("newline count above fill count");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ttyb_pkg::S_EMIT |-> cnt_ff < tot_ff)
      else $error("emit pass ran past scanned length");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == ttyb_pkg::KIND_EMPTY |-> last_ff && obyte_ff == 8'h00)
      else $error("empty marker not final or not zero");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ttyb_pkg::S_SCAN |-> fill_ff != '0)
      else $error("scan started on empty store");

endmodule

`default_nettype wire

// ===== rtl/tty_line_discipline_buffer.sv =====
// ----------------------------------------------------------------------------
// tty_line_discipline_buffer
// Terminal input line buffer with echo, erase and line-terminated reads.
// ----------------------------------------------------------------------------
// A push item carries one received byte; a read item asks for up to
// read_limit bytes (saturated to MAX_READ). The front classifies each item and
// parks it in a two-entry command queue, which takes requests while the back
// end is busy or the output is stalled, until it is full. The back end owns
// the line store, a ring of STORE_DEPTH bytes behind one registered read port;
// the store is not cleared after reset and needs no clearing pass. A push is
// stored and an erase fetches the last byte to check for a newline; either is
// echoed when echo is on (one byte, or three for a backspace). A read walks
// the bytes twice through the single read port, once to find the length and
// the newlines consumed (which set the readable flag carried on every result)
// and once to deliver them at one byte per cycle while the output is not
// stalled. An empty read answers with one marker result. Configuration writes
// are always taken (csr_ready is tied high) and must only happen while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tty_line_discipline_buffer #(
   parameter int STORE_DEPTH = ttyb_pkg::DEF_STORE_DEPTH,
   parameter int MAX_READ    = ttyb_pkg::DEF_MAX_READ
) (
   input  wire                           clock,
   input  wire                           reset,
   // request channel
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire                           req_cmd,
   input  wire  [7:0]                    req_in_byte,
   input  wire  [ttyb_pkg::LIMIT_W-1:0]  req_read_limit,
   // result channel
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last,
   output logic                          rsp_readable,
   output logic                          rsp_overflow,
   // configuration write channel
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire  [1:0]                    csr_index,
   input  wire                           csr_data
);

   ttyb_pkg::cfg_type cfg_ff, cfg_in;
   logic              q_valid;
   logic              q_pop;
   ttyb_pkg::cmd_type q_item;

   assign csr_ready = 1'b1;

   // Decode a register write; an index past the list is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ttyb_pkg::REG_CRLF:  cfg_in.crlf  = csr_data;
            ttyb_pkg::REG_ECHO:  cfg_in.echo  = csr_data;
            ttyb_pkg::REG_CANON: cfg_in.canon = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{crlf: 1'b1, echo: 1'b1, canon: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: translate, classify and queue each transfer on the request side.
   ttyb_front #(
      .MAX_READ (MAX_READ)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_in_byte    (req_in_byte),
      .req_read_limit (req_read_limit),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   // Back: ring store, counters, echo and read sequencing, result register.
   ttyb_back #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_readable (rsp_readable),
      .rsp_overflow (rsp_overflow)
   );

endmodule

`default_nettype wire
